[rtl/core/tat_pkg.sv]
`timescale 1ns / 1ps

package tat_pkg;

    localparam int REQ_W    = 2;
    localparam int COUNT_W  = 13;
    localparam int INDEX_W  = 10;
    localparam int RANK_W   = 12;
    localparam int TOPIC_W  = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [CFG_W-1:0]   TOPICS_RESET = 11'd1024;

    // register index, taken from paddr[2]
    localparam logic CFG_TOPICS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        OP_BEGIN   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_ADD     = 2'd2,
        OP_REPLACE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_TOPIC    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_OFFS,
        S_SLOT,
        S_OLDC,
        S_NEWC,
        S_CLEAR
    } back_state_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COUNT_W-1:0] word_count;
        logic [INDEX_W-1:0] word_index;
        logic [RANK_W-1:0]  word_rank;
        logic [TOPIC_W-1:0] topic;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TOPIC_W-1:0]  prev_topic;
        logic [COUNT_W-1:0]  prev_topic_count;
        logic [COUNT_W-1:0]  new_topic_count;
        logic [COUNT_W-1:0]  total_words;
    } out_word_t;

    typedef struct packed {
        op_t                op;
        logic [COUNT_W-1:0] word_count;
        logic [INDEX_W-1:0] word_index;
        logic [RANK_W-1:0]  word_rank;
        logic [TOPIC_W-1:0] topic;
    } cmd_t;

    function automatic logic [COUNT_W-1:0] cnt_up(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] cnt_down(input logic [COUNT_W-1:0] c);
        return (c == '0) ? c : c - COUNT_W'(1);
    endfunction

endpackage

[rtl/core/topic_assignment_table_top.sv]
// Per-document topic assignment table for LDA sampling. Requests enter a
// two-word queue and are carried out by a sequencer over three memories
// (word start offsets, slot topics, topic counts); results leave through a
// two-word queue. A load or a request with a bad word index is answered from
// the idle state, an add after the offset read and the slot and count reads,
// and a replace with the new count write that follows the old count write,
// set by the chain offset read -> slot read -> count read and the single
// write port of the count memory. A begin sweeps the slot and count memories
// one entry a cycle; the same sweep runs after reset, and full stays high
// while it runs. The topics_in_use register sits at byte address 0.
`timescale 1ns / 1ps

module topic_assignment_table_top
#(
    parameter int MAX_TOPICS      = 1024,
    parameter int MAX_UNIQUE      = 1024,
    parameter int MAX_OCCURRENCES = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  tat_pkg::in_word_t            item,
    output logic                         empty,
    input  logic                         pop,
    output tat_pkg::out_word_t           result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tat_pkg::ADDR_W-1:0]   paddr,
    input  logic [tat_pkg::DATA_W-1:0]   pwdata,
    output logic [tat_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    logic [tat_pkg::CFG_W-1:0] topics_reg;
    logic                      cfg_wr;
    logic                      init_busy;
    logic                      cmd_valid, cmd_pop;
    tat_pkg::cmd_t             cmd;
    logic                      res_push, res_full;
    tat_pkg::out_word_t        res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[2] == tat_pkg::CFG_TOPICS_IN_USE);
    assign prdata = (paddr[2] == tat_pkg::CFG_TOPICS_IN_USE)
                  ? tat_pkg::DATA_W'(topics_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topics_reg <= tat_pkg::TOPICS_RESET;
        end
        else if (cfg_wr)
        begin
            topics_reg <= pwdata[tat_pkg::CFG_W-1:0];
        end
    end

    tat_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .init_busy (init_busy),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tat_back
    #(
        .MAX_TOPICS      (MAX_TOPICS),
        .MAX_UNIQUE      (MAX_UNIQUE),
        .MAX_OCCURRENCES (MAX_OCCURRENCES)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .topics_in_use (topics_reg),
        .res_full      (res_full),
        .res_push      (res_push),
        .res           (res),
        .init_busy     (init_busy)
    );

    tat_res_queue u_res_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into a full queue");

    a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(init_busy) |-> empty)
        else $error("result produced during the reset sweep");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (topics_reg == $past(pwdata[tat_pkg::CFG_W-1:0])))
        else $error("topics_in_use not updated by write");

endmodule

[rtl/core/tat_front.sv]
`timescale 1ns / 1ps

module tat_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tat_pkg::in_word_t item,
    input  logic             init_busy,
    output logic             full,
    output logic             cmd_valid,
    output tat_pkg::cmd_t    cmd,
    input  logic             cmd_pop
);

    tat_pkg::cmd_t q_reg [2];
    tat_pkg::cmd_t entry;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    always_comb
    begin
        entry.op         = tat_pkg::op_t'(item.req_type);
        entry.word_count = item.word_count;
        entry.word_index = item.word_index;
        entry.word_rank  = item.word_rank;
        entry.topic      = item.topic;
    end

    assign full      = (count_reg == 2'd2) || init_busy;
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && (count_reg != 2'd0);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

[rtl/core/tat_res_queue.sv]
`timescale 1ns / 1ps

module tat_res_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tat_pkg::out_word_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output tat_pkg::out_word_t rdata
);

    tat_pkg::out_word_t q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/core/tat_back.sv]
`timescale 1ns / 1ps

module tat_back
#(
    parameter int MAX_TOPICS      = 1024,
    parameter int MAX_UNIQUE      = 1024,
    parameter int MAX_OCCURRENCES = 4096
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  tat_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    input  logic [tat_pkg::CFG_W-1:0]   topics_in_use,
    input  logic                        res_full,
    output logic                        res_push,
    output tat_pkg::out_word_t          res,
    output logic                        init_busy
);

    localparam int COUNT_W   = tat_pkg::COUNT_W;
    localparam int TOPIC_W   = tat_pkg::TOPIC_W;
    localparam int TOPIC_AW  = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
    localparam int UNIQ_AW   = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int SLOT_AW   = (MAX_OCCURRENCES > 1) ? $clog2(MAX_OCCURRENCES) : 1;
    localparam int OCC_W     = $clog2(MAX_OCCURRENCES + 1);
    localparam int UNQ_W     = $clog2(MAX_UNIQUE + 1);
    localparam int CLR_DEPTH = (MAX_OCCURRENCES > MAX_TOPICS) ? MAX_OCCURRENCES : MAX_TOPICS;
    localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
    localparam int TX_W      = (TOPIC_AW > TOPIC_W) ? TOPIC_AW : TOPIC_W;
    localparam int IX_W      = (UNIQ_AW > tat_pkg::INDEX_W) ? UNIQ_AW : tat_pkg::INDEX_W;
    localparam int SUM_W     = ((OCC_W > tat_pkg::RANK_W) ? OCC_W : tat_pkg::RANK_W) + 1;
    localparam int TOT_W     = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;
    localparam int LSUM_W    = TOT_W + 1;

    function automatic logic [TOPIC_AW-1:0] topic_addr(input logic [TOPIC_W-1:0] t);
        logic [TX_W-1:0] e;
        e = TX_W'(t);
        return e[TOPIC_AW-1:0];
    endfunction

    // storage
    logic [OCC_W-1:0]   off_mem   [MAX_UNIQUE];
    logic [TOPIC_W-1:0] slot_mem  [MAX_OCCURRENCES];
    logic [COUNT_W-1:0] count_mem [MAX_TOPICS];

    logic [OCC_W-1:0]   off_rd_reg;
    logic [TOPIC_W-1:0] slot_rd_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;

    logic                off_we, off_re;
    logic [UNIQ_AW-1:0]  off_waddr, off_raddr;
    logic [OCC_W-1:0]    off_wdata;
    logic                slot_we, slot_re;
    logic [SLOT_AW-1:0]  slot_waddr, slot_raddr;
    logic [TOPIC_W-1:0]  slot_wdata;
    logic                cnt_we, cnt_re;
    logic [TOPIC_AW-1:0] cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0]  cnt_wdata;

    tat_pkg::back_state_t state_reg, state_next;
    tat_pkg::cmd_t        cmd_reg, cmd_next;
    logic [UNQ_W-1:0]     unique_reg, unique_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [CLR_W-1:0]     clr_reg, clr_next;
    logic [SLOT_AW-1:0]   slot_addr_reg, slot_addr_next;
    logic [TOPIC_W-1:0]   prev_topic_reg, prev_topic_next;
    logic [COUNT_W-1:0]   new_cnt_reg, new_cnt_next;
    logic [COUNT_W-1:0]   old_cnt_reg, old_cnt_next;
    logic [COUNT_W-1:0]   new_res_reg, new_res_next;

    logic [IX_W-1:0]    idx_ext;
    logic [SUM_W-1:0]   slot_sum;
    logic [LSUM_W-1:0]  load_sum;
    logic [TOT_W-1:0]   tot_ext;
    logic               word_ok, slot_ok, topic_ok, load_ok, clr_last;
    logic [COUNT_W-1:0] oc, base;
    tat_pkg::status_t   res_status;

    assign idx_ext  = IX_W'(cmd.word_index);
    assign word_ok  = (int'(cmd.word_index) < int'(unique_reg))
                   && (int'(cmd.word_index) < MAX_UNIQUE);
    assign load_sum = LSUM_W'(occ_reg) + LSUM_W'(cmd.word_count);
    assign load_ok  = (int'(unique_reg) < MAX_UNIQUE)
                   && (int'(load_sum) <= MAX_OCCURRENCES);
    assign slot_sum = SUM_W'(off_rd_reg) + SUM_W'(cmd_reg.word_rank);
    assign slot_ok  = (int'(slot_sum) < int'(occ_reg))
                   && (int'(slot_sum) < MAX_OCCURRENCES);
    assign topic_ok = ({1'b0, cmd_reg.topic} < topics_in_use)
                   && (int'(cmd_reg.topic) < MAX_TOPICS);
    assign clr_last = (clr_reg == CLR_W'(CLR_DEPTH - 1));
    assign oc       = tat_pkg::cnt_down(cnt_rd_reg);
    assign base     = (prev_topic_reg == cmd_reg.topic) ? oc : new_cnt_reg;
    assign init_busy = (state_reg == tat_pkg::S_INIT);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        unique_next     = unique_reg;
        occ_next        = occ_reg;
        clr_next        = clr_reg;
        slot_addr_next  = slot_addr_reg;
        prev_topic_next = prev_topic_reg;
        new_cnt_next    = new_cnt_reg;
        old_cnt_next    = old_cnt_reg;
        new_res_next    = new_res_reg;

        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res_status = tat_pkg::ST_OK;
        res.prev_topic       = '0;
        res.prev_topic_count = '0;
        res.new_topic_count  = '0;

        off_we     = 1'b0;
        off_waddr  = unique_reg[UNIQ_AW-1:0];
        off_wdata  = occ_reg;
        off_re     = 1'b0;
        off_raddr  = idx_ext[UNIQ_AW-1:0];
        slot_we    = 1'b0;
        slot_waddr = slot_addr_reg;
        slot_wdata = cmd_reg.topic;
        slot_re    = 1'b0;
        slot_raddr = slot_sum[SLOT_AW-1:0];
        cnt_we     = 1'b0;
        cnt_waddr  = topic_addr(cmd_reg.topic);
        cnt_wdata  = new_res_reg;
        cnt_re     = 1'b0;
        cnt_raddr  = topic_addr(cmd_reg.topic);

        case (state_reg)
            tat_pkg::S_INIT, tat_pkg::S_CLEAR:
            begin
                slot_we    = (int'(clr_reg) < MAX_OCCURRENCES);
                slot_waddr = clr_reg[SLOT_AW-1:0];
                slot_wdata = '0;
                cnt_we     = (int'(clr_reg) < MAX_TOPICS);
                cnt_waddr  = clr_reg[TOPIC_AW-1:0];
                cnt_wdata  = '0;
                clr_next   = clr_reg + CLR_W'(1);
                if (clr_last)
                begin
                    res_push   = (state_reg == tat_pkg::S_CLEAR);
                    state_next = tat_pkg::S_IDLE;
                end
            end
            tat_pkg::S_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.op)
                        tat_pkg::OP_BEGIN:
                        begin
                            unique_next = '0;
                            occ_next    = '0;
                            clr_next    = '0;
                            state_next  = tat_pkg::S_CLEAR;
                        end
                        tat_pkg::OP_LOAD:
                        begin
                            res_push = 1'b1;
                            if (load_ok)
                            begin
                                off_we      = 1'b1;
                                unique_next = unique_reg + UNQ_W'(1);
                                occ_next    = load_sum[OCC_W-1:0];
                            end
                            else
                            begin
                                res_status = tat_pkg::ST_OVERFLOW;
                            end
                        end
                        default:
                        begin
                            if (word_ok)
                            begin
                                off_re     = 1'b1;
                                state_next = tat_pkg::S_OFFS;
                            end
                            else
                            begin
                                res_push   = 1'b1;
                                res_status = tat_pkg::ST_RANGE;
                            end
                        end
                    endcase
                end
            end
            tat_pkg::S_OFFS:
            begin
                if (!slot_ok)
                begin
                    res_push   = 1'b1;
                    res_status = tat_pkg::ST_RANGE;
                    state_next = tat_pkg::S_IDLE;
                end
                else if (!topic_ok)
                begin
                    res_push   = 1'b1;
                    res_status = tat_pkg::ST_TOPIC;
                    state_next = tat_pkg::S_IDLE;
                end
                else
                begin
                    slot_re        = 1'b1;
                    cnt_re         = 1'b1;
                    slot_addr_next = slot_sum[SLOT_AW-1:0];
                    state_next     = tat_pkg::S_SLOT;
                end
            end
            tat_pkg::S_SLOT:
            begin
                slot_we = 1'b1;
                if (cmd_reg.op == tat_pkg::OP_ADD)
                begin
                    cnt_we              = 1'b1;
                    cnt_wdata           = tat_pkg::cnt_up(cnt_rd_reg);
                    res_push            = 1'b1;
                    res.new_topic_count = tat_pkg::cnt_up(cnt_rd_reg);
                    state_next          = tat_pkg::S_IDLE;
                end
                else
                begin
                    cnt_re          = 1'b1;
                    cnt_raddr       = topic_addr(slot_rd_reg);
                    prev_topic_next = slot_rd_reg;
                    new_cnt_next    = cnt_rd_reg;
                    state_next      = tat_pkg::S_OLDC;
                end
            end
            tat_pkg::S_OLDC:
            begin
                cnt_we       = 1'b1;
                cnt_waddr    = topic_addr(prev_topic_reg);
                cnt_wdata    = oc;
                old_cnt_next = oc;
                new_res_next = tat_pkg::cnt_up(base);
                state_next   = tat_pkg::S_NEWC;
            end
            tat_pkg::S_NEWC:
            begin
                cnt_we               = 1'b1;
                res_push             = 1'b1;
                res.prev_topic       = prev_topic_reg;
                res.prev_topic_count = old_cnt_reg;
                res.new_topic_count  = new_res_reg;
                state_next           = tat_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tat_pkg::S_IDLE;
            end
        endcase

        tot_ext         = TOT_W'(occ_next);
        res.status      = res_status;
        res.total_words = tot_ext[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tat_pkg::S_INIT;
            unique_reg <= '0;
            occ_reg    <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            unique_reg <= unique_next;
            occ_reg    <= occ_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        slot_addr_reg  <= slot_addr_next;
        prev_topic_reg <= prev_topic_next;
        new_cnt_reg    <= new_cnt_next;
        old_cnt_reg    <= old_cnt_next;
        new_res_reg    <= new_res_next;
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
        begin
            off_mem[off_waddr] <= off_wdata;
        end
        if (off_re)
        begin
            off_rd_reg <= off_mem[off_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= count_mem[cnt_raddr];
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tat_pkg::*;

    localparam int MAX_TOPICS      = 1024;
    localparam int MAX_UNIQUE      = 1024;
    localparam int MAX_OCCURRENCES = 4096;
    localparam int SWEEP_CYCLES    = 4200;
    localparam int STALL_CYCLES    = 400;

    class assignment_shadow;
        int unsigned word_offs [MAX_UNIQUE];
        int unsigned slot_topic [MAX_OCCURRENCES];
        int unsigned topic_count [MAX_TOPICS];
        int unsigned n_unique;
        int unsigned n_occ;
        int unsigned topics_cfg;
        out_word_t   awaited [$];
        int          errors;

        function new();
            foreach (word_offs[i])
                word_offs[i] = 0;
            clear_document();
            topics_cfg = TOPICS_RESET;
            errors = 0;
        endfunction

        function void clear_document();
            foreach (slot_topic[i])
                slot_topic[i] = 0;
            foreach (topic_count[i])
                topic_count[i] = 0;
            n_unique = 0;
            n_occ = 0;
        endfunction

        function int word_len(int i);
            int unsigned stop;
            stop = (i + 1 < n_unique) ? word_offs[i + 1] : n_occ;
            return stop - word_offs[i];
        endfunction

        function void take_request(in_word_t w);
            out_word_t   r;
            int unsigned s;
            int unsigned lim;
            int unsigned old;
            r = '0;
            s = 0;
            lim = (topics_cfg < MAX_TOPICS) ? topics_cfg : MAX_TOPICS;
            case (op_t'(w.req_type))
                OP_BEGIN:
                    clear_document();
                OP_LOAD:
                begin
                    if (n_unique >= MAX_UNIQUE || w.word_count > MAX_OCCURRENCES - n_occ)
                        r.status = ST_OVERFLOW;
                    else
                    begin
                        word_offs[n_unique] = n_occ;
                        n_unique++;
                        n_occ += w.word_count;
                    end
                end
                default:
                begin
                    if (w.word_index >= n_unique)
                        r.status = ST_RANGE;
                    else
                    begin
                        s = word_offs[w.word_index] + w.word_rank;
                        if (s >= n_occ || s >= MAX_OCCURRENCES)
                            r.status = ST_RANGE;
                    end
                    if (r.status == ST_OK && w.topic >= lim)
                        r.status = ST_TOPIC;
                    if (r.status == ST_OK)
                    begin
                        if (op_t'(w.req_type) == OP_REPLACE)
                        begin
                            old = slot_topic[s];
                            r.prev_topic = old[TOPIC_W-1:0];
                            if (topic_count[old] > 0)
                                topic_count[old]--;
                            r.prev_topic_count = topic_count[old][COUNT_W-1:0];
                        end
                        slot_topic[s] = w.topic;
                        if (topic_count[w.topic] < COUNT_MAX)
                            topic_count[w.topic]++;
                        r.new_topic_count = topic_count[w.topic][COUNT_W-1:0];
                    end
                end
            endcase
            r.total_words = n_occ[COUNT_W-1:0];
            awaited.push_back(r);
        endfunction

        function void match_result(out_word_t r);
            out_word_t e;
            if (awaited.size() == 0)
            begin
                $error("result word with no request waiting");
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (r.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, r.status);
                errors++;
            end
            if (r.prev_topic !== e.prev_topic)
            begin
                $error("prev_topic: expected %0d, actual %0d", e.prev_topic, r.prev_topic);
                errors++;
            end
            if (r.prev_topic_count !== e.prev_topic_count)
            begin
                $error("prev_topic_count: expected %0d, actual %0d",
                       e.prev_topic_count, r.prev_topic_count);
                errors++;
            end
            if (r.new_topic_count !== e.new_topic_count)
            begin
                $error("new_topic_count: expected %0d, actual %0d",
                       e.new_topic_count, r.new_topic_count);
                errors++;
            end
            if (r.total_words !== e.total_words)
            begin
                $error("total_words: expected %0d, actual %0d", e.total_words, r.total_words);
                errors++;
            end
        endfunction
    endclass

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              push    = 1'b0;
    in_word_t          item    = '0;
    logic              pop     = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic              full;
    logic              empty;
    out_word_t         result;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              full_s   = 1'b1;
    logic              empty_s  = 1'b1;
    out_word_t         result_s = '0;

    assignment_shadow  shadow = new();
    int                item_total  = 0;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                stall_asks  = 0;
    int                stall_seen  = 0;

    topic_assignment_table_top
    #(
        .MAX_TOPICS      (MAX_TOPICS),
        .MAX_UNIQUE      (MAX_UNIQUE),
        .MAX_OCCURRENCES (MAX_OCCURRENCES)
    )
    dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // outputs settle between edges; handshakes use these copies
    always @(negedge clk)
    begin
        full_s   <= full;
        empty_s  <= empty;
        result_s <= result;
    end

    function automatic in_word_t make_request(op_t op, int cnt, int idx, int rank, int topic);
        in_word_t w;
        w.req_type   = op;
        w.word_count = cnt[COUNT_W-1:0];
        w.word_index = idx[INDEX_W-1:0];
        w.word_rank  = rank[RANK_W-1:0];
        w.topic      = topic[TOPIC_W-1:0];
        return w;
    endfunction

    function automatic int pick_topic();
        int lim;
        lim = (shadow.topics_cfg < MAX_TOPICS) ? shadow.topics_cfg : MAX_TOPICS;
        if (lim > 0 && $urandom_range(9) < 8)
            return $urandom_range(lim - 1, 0);
        return $urandom_range(1023, 0);
    endfunction

    function automatic int random_load_count();
        if ($urandom_range(19) == 0)
            return $urandom_range(8191, 0);
        return $urandom_range(24, 0);
    endfunction

    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full_s !== 1'b0)
            @(posedge clk);
        shadow.take_request(w);
        item_total++;
    endtask

    task automatic wait_drained();
        while (shadow.awaited.size() != 0)
            @(posedge clk);
        // margin before the next phase
        repeat (SWEEP_CYCLES)
            @(posedge clk);
    endtask

    task automatic cfg_access(input logic wr, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {CFG_TOPICS_IN_USE, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (pready !== 1'b1)
            @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_topics(input int v);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] want;
        wait_drained();
        want = DATA_W'(v[CFG_W-1:0]);
        cfg_access(1'b1, DATA_W'(v), rd);
        shadow.topics_cfg = want;
        cfg_access(1'b0, '0, rd);
        if (rd !== want)
        begin
            $error("topics_in_use: expected %0d, actual %0d", want, rd);
            shadow.errors++;
        end
    endtask

    task automatic run_document(input int n_words, input int n_access);
        int pick;
        int wi;
        int j;
        send_word(make_request(OP_BEGIN, $urandom_range(8191, 0), $urandom_range(1023, 0),
                               $urandom_range(4095, 0), $urandom_range(1023, 0)));
        repeat (n_words)
            send_word(make_request(OP_LOAD, random_load_count(), 0, 0, 0));
        repeat (n_access)
        begin
            pick = $urandom_range(99);
            wi = -1;
            for (int k = 0; k < 4 && wi < 0 && pick >= 20 && shadow.n_unique > 0; k++)
            begin
                j = $urandom_range(shadow.n_unique - 1, 0);
                if (shadow.word_len(j) > 0)
                    wi = j;
            end
            if (pick < 5)
                send_word(make_request(OP_LOAD, random_load_count(), 0, 0, 0));
            else if (wi >= 0)
                send_word(make_request(pick < 55 ? OP_ADD : OP_REPLACE,
                                       $urandom_range(8191, 0), wi,
                                       $urandom_range(shadow.word_len(wi) - 1, 0),
                                       pick_topic()));
            else
                send_word(make_request($urandom_range(1) ? OP_ADD : OP_REPLACE,
                                       $urandom_range(8191, 0), $urandom_range(1023, 0),
                                       $urandom_range(4095, 0), $urandom_range(1023, 0)));
        end
    endtask

    task automatic random_phase(input int n_items);
        int target;
        target = item_total + n_items;
        while (item_total < target)
            run_document($urandom_range(10, 1), $urandom_range(40, 8));
        push <= 1'b0;
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (pop && empty_s === 1'b0)
                shadow.match_result(result_s);
            if (stall_seen != stall_asks)
            begin
                stall_seen = stall_asks;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin : stimulus
        tx_idle_pct = 17;
        rx_idle_pct = 81;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no words loaded yet
        send_word(make_request(OP_ADD, 0, 0, 0, 0));
        send_word(make_request(OP_BEGIN, 0, 0, 0, 0));
        send_word(make_request(OP_LOAD, 0, 0, 0, 0));
        send_word(make_request(OP_LOAD, 3, 0, 0, 0));
        send_word(make_request(OP_LOAD, 4096, 0, 0, 0));
        send_word(make_request(OP_LOAD, 4093, 0, 0, 0));
        send_word(make_request(OP_LOAD, 0, 0, 0, 0));
        send_word(make_request(OP_LOAD, 1, 0, 0, 0));
        send_word(make_request(OP_LOAD, 8191, 0, 0, 0));
        send_word(make_request(OP_ADD, 0, 0, 0, 1023));
        send_word(make_request(OP_REPLACE, 0, 1, 0, 1023));
        send_word(make_request(OP_REPLACE, 0, 1, 1, 5));
        send_word(make_request(OP_ADD, 0, 2, 4092, 0));
        send_word(make_request(OP_ADD, 0, 2, 4093, 0));
        send_word(make_request(OP_ADD, 0, 3, 0, 0));
        send_word(make_request(OP_REPLACE, 0, 1023, 4095, 1023));
        send_word(make_request(OP_ADD, 0, 1, 0, 7));
        send_word(make_request(OP_REPLACE, 0, 0, 4095, 3));
        send_word(make_request(OP_BEGIN, 8191, 1023, 4095, 1023));
        send_word(make_request(OP_REPLACE, 0, 0, 0, 0));
        send_word(make_request(OP_LOAD, 4096, 0, 0, 0));
        send_word(make_request(OP_REPLACE, 8191, 0, 4095, 1023));
        push <= 1'b0;

        set_topics(0);
        random_phase(40);

        set_topics(1);
        stall_asks++;
        random_phase(280);

        tx_idle_pct = 81;
        rx_idle_pct = 17;
        set_topics(2047);
        random_phase(280);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_topics($urandom_range(1023, 2));
        stall_asks++;
        random_phase(320);

        set_topics(1024);
        random_phase(150);

        rx_idle_pct = 0;
        wait_drained();
        if (shadow.errors == 0 && shadow.awaited.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #60000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/core/tat_pkg.sv
rtl/core/tat_front.sv
rtl/core/tat_res_queue.sv
rtl/core/tat_back.sv
rtl/core/topic_assignment_table_top.sv
tb/tb_top.sv
